### design/bsf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsf_pkg: shared types and constants for the BMP stream to framebuffer core
// Screen geometry, header layout, codes and the job record that passes
// from the front end to the write sequencer.
// ----------------------------------------------------------------------------
package bsf_pkg;

  localparam int unsigned SCREEN_WIDTH  = 320;
  localparam int unsigned SCREEN_HEIGHT = 240;
  localparam int unsigned HEADER_BYTES  = 1078;

  localparam int unsigned HALF_WIDTH  = SCREEN_WIDTH / 2;
  localparam int unsigned HALF_HEIGHT = SCREEN_HEIGHT / 2;

  localparam int unsigned HCNT_W = 11;
  localparam int unsigned COL_W  = $clog2(SCREEN_WIDTH + 1);
  localparam int unsigned ROW_W  = $clog2(SCREEN_HEIGHT);

  // header byte positions
  localparam int unsigned SIG_END    = 2;
  localparam int unsigned WIDTH_POS  = 18;
  localparam int unsigned HEIGHT_POS = 22;
  localparam int unsigned FIELD_LEN  = 4;

  // "BM", little endian
  localparam logic [15:0] SIG_BM = 16'h4D42;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic KIND_PIXEL  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_DATA  = 2'd1,
    OP_END   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_PIXELS = 2'd1,
    PH_DONE   = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT_HDR = 3'd1,
    ST_BAD_SIG   = 3'd2,
    ST_BAD_SIZE  = 3'd3,
    ST_SHORT_PIX = 3'd4
  } status_t;

  // one queued unit of work: optional pixel write(s), then optional status
  typedef struct packed {
    logic        has_pix;
    logic        quad;
    logic        has_st;
    status_t     st;
    logic [31:0] addr;
    logic [7:0]  pixel;
  } job_t;

endpackage

### design/bsf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsf_front: byte parser
// Walks the header, checks signature and size, tracks row and column of
// pixel bytes and turns every input item into at most one queued job.
// ----------------------------------------------------------------------------
module bsf_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               acc,
  input  logic [1:0]         operation,
  input  logic [7:0]         data_byte,
  input  logic [31:0]        pixel_base,
  output logic               push,
  output bsf_pkg::job_t      job
);

  bsf_pkg::phase_t                 phase_r, phase_nxt;
  logic [bsf_pkg::HCNT_W-1:0]      hcnt_r, hcnt_nxt;
  logic [15:0]                     sig_r, sig_nxt;
  logic [31:0]                     width_r, width_nxt;
  logic [31:0]                     height_r, height_nxt;
  logic                            dbl_r, dbl_nxt;
  logic [bsf_pkg::ROW_W-1:0]       row_r, row_nxt;
  logic [bsf_pkg::COL_W-1:0]       col_r, col_nxt;

  logic [bsf_pkg::HCNT_W-1:0]      wpos, hpos;
  logic [bsf_pkg::COL_W-1:0]       col_inc;
  logic [31:0]                     offset, offset_sc;

  assign wpos    = hcnt_r - bsf_pkg::HCNT_W'(bsf_pkg::WIDTH_POS);
  assign hpos    = hcnt_r - bsf_pkg::HCNT_W'(bsf_pkg::HEIGHT_POS);
  assign col_inc = col_r + bsf_pkg::COL_W'(1);

  // row-major offset; half size images land at twice the coordinates
  assign offset    = 32'(row_r) * 32'(bsf_pkg::SCREEN_WIDTH) + 32'(col_r);
  assign offset_sc = dbl_r ? {offset[30:0], 1'b0} : offset;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= bsf_pkg::PH_HEADER;
      hcnt_r   <= '0;
      sig_r    <= '0;
      width_r  <= '0;
      height_r <= '0;
      dbl_r    <= 1'b0;
      row_r    <= '0;
      col_r    <= '0;
    end else begin
      phase_r  <= phase_nxt;
      hcnt_r   <= hcnt_nxt;
      sig_r    <= sig_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      dbl_r    <= dbl_nxt;
      row_r    <= row_nxt;
      col_r    <= col_nxt;
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    hcnt_nxt   = hcnt_r;
    sig_nxt    = sig_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    dbl_nxt    = dbl_r;
    row_nxt    = row_r;
    col_nxt    = col_r;
    push       = 1'b0;
    job.has_pix = 1'b0;
    job.quad    = dbl_r;
    job.has_st  = 1'b0;
    job.st      = bsf_pkg::ST_OK;
    job.addr    = pixel_base + offset_sc;
    job.pixel   = data_byte;

    if (acc) begin
      unique case (operation)
        bsf_pkg::OP_START: begin
          phase_nxt  = bsf_pkg::PH_HEADER;
          hcnt_nxt   = '0;
          sig_nxt    = '0;
          width_nxt  = '0;
          height_nxt = '0;
          dbl_nxt    = 1'b0;
          row_nxt    = '0;
          col_nxt    = '0;
        end
        bsf_pkg::OP_DATA: begin
          unique case (phase_r)
            bsf_pkg::PH_HEADER: begin
              if (hcnt_r < bsf_pkg::HCNT_W'(bsf_pkg::SIG_END)) begin
                sig_nxt = sig_r | ({8'h00, data_byte} << {hcnt_r[0], 3'b000});
              end
              if (wpos < bsf_pkg::HCNT_W'(bsf_pkg::FIELD_LEN)) begin
                width_nxt = width_r | ({24'h0, data_byte} << {wpos[1:0], 3'b000});
              end
              if (hpos < bsf_pkg::HCNT_W'(bsf_pkg::FIELD_LEN)) begin
                height_nxt = height_r | ({24'h0, data_byte} << {hpos[1:0], 3'b000});
              end
              hcnt_nxt = hcnt_r + bsf_pkg::HCNT_W'(1);
              if (hcnt_r == bsf_pkg::HCNT_W'(bsf_pkg::HEADER_BYTES - 1)) begin
                // size fields lie well before the last header byte
                if (sig_r != bsf_pkg::SIG_BM) begin
                  push      = 1'b1;
                  job.has_st = 1'b1;
                  job.st    = bsf_pkg::ST_BAD_SIG;
                  phase_nxt = bsf_pkg::PH_DONE;
                end else if (width_r == 32'(bsf_pkg::HALF_WIDTH) &&
                             height_r == 32'(bsf_pkg::HALF_HEIGHT)) begin
                  dbl_nxt   = 1'b1;
                  phase_nxt = bsf_pkg::PH_PIXELS;
                  row_nxt   = bsf_pkg::ROW_W'(height_r - 32'd1);
                  col_nxt   = '0;
                end else if (width_r == 32'(bsf_pkg::SCREEN_WIDTH) &&
                             height_r == 32'(bsf_pkg::SCREEN_HEIGHT)) begin
                  dbl_nxt   = 1'b0;
                  phase_nxt = bsf_pkg::PH_PIXELS;
                  row_nxt   = bsf_pkg::ROW_W'(height_r - 32'd1);
                  col_nxt   = '0;
                end else begin
                  push      = 1'b1;
                  job.has_st = 1'b1;
                  job.st    = bsf_pkg::ST_BAD_SIZE;
                  phase_nxt = bsf_pkg::PH_DONE;
                end
              end
            end
            bsf_pkg::PH_PIXELS: begin
              push        = 1'b1;
              job.has_pix = 1'b1;
              col_nxt     = col_inc;
              if (32'(col_inc) >= width_r) begin
                col_nxt = '0;
                if (row_r == '0) begin
                  job.has_st = 1'b1;
                  job.st     = bsf_pkg::ST_OK;
                  phase_nxt  = bsf_pkg::PH_DONE;
                end else begin
                  row_nxt = row_r - bsf_pkg::ROW_W'(1);
                end
              end
            end
            default: ;
          endcase
        end
        bsf_pkg::OP_END: begin
          if (phase_r == bsf_pkg::PH_HEADER) begin
            push       = 1'b1;
            job.has_st = 1'b1;
            job.st     = bsf_pkg::ST_SHORT_HDR;
            phase_nxt  = bsf_pkg::PH_DONE;
          end else if (phase_r == bsf_pkg::PH_PIXELS) begin
            push       = 1'b1;
            job.has_st = 1'b1;
            job.st     = bsf_pkg::ST_SHORT_PIX;
            phase_nxt  = bsf_pkg::PH_DONE;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

### design/bsf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsf_queue: job queue
// Small register FIFO between the parser and the write sequencer.
// ----------------------------------------------------------------------------
module bsf_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  bsf_pkg::job_t push_job,
  input  logic          pop,
  output bsf_pkg::job_t pop_job,
  output logic          full,
  output logic          empty
);

  bsf_pkg::job_t                mem_r [bsf_pkg::QUEUE_DEPTH];
  logic [bsf_pkg::QPTR_W-1:0]   wptr_r, wptr_nxt;
  logic [bsf_pkg::QPTR_W-1:0]   rptr_r, rptr_nxt;
  logic [bsf_pkg::QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                         do_push, do_pop;

  assign full    = cnt_r == bsf_pkg::QCNT_W'(bsf_pkg::QUEUE_DEPTH);
  assign empty   = cnt_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_job = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = do_push ? wptr_r + bsf_pkg::QPTR_W'(1) : wptr_r;
    rptr_nxt = do_pop ? rptr_r + bsf_pkg::QPTR_W'(1) : rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + bsf_pkg::QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - bsf_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_job;
    end
  end

endmodule

### design/bsf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsf_back: write sequencer
// Expands each job into its pixel writes and status into a registered
// output stage, one result per cycle while out_stall does not hold it.
// ----------------------------------------------------------------------------
module bsf_back (
  input  logic          clk,
  input  logic          rst_n,
  input  bsf_pkg::job_t q_job,
  input  logic          q_empty,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic          out_kind,
  output logic [31:0]   out_address,
  output logic [7:0]    out_pixel,
  output logic [2:0]    out_status,
  output logic          out_last
);

  bsf_pkg::job_t cur_r, cur_nxt;
  logic          cur_valid_r, cur_valid_nxt;
  logic [2:0]    step_r, step_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          kind_r;
  logic [31:0]   addr_r;
  logic [7:0]    pixel_r;
  logic [2:0]    status_r;
  logic          last_r;

  logic [2:0]    npix, nres;
  logic          adv, is_last, job_done;
  logic          res_kind;
  logic [31:0]   res_addr, sub_off;

  always_comb begin
    npix = cur_r.has_pix ? (cur_r.quad ? 3'd4 : 3'd1) : 3'd0;
    nres = npix + {2'b00, cur_r.has_st};
  end

  assign adv      = cur_valid_r && (!out_valid_r || !out_stall);
  assign is_last  = step_r == nres - 3'd1;
  assign job_done = adv && is_last;
  assign q_pop    = !q_empty && (!cur_valid_r || job_done);

  // quad order: top left, top right, bottom left, bottom right
  always_comb begin
    case (step_r[1:0])
      2'd0:    sub_off = 32'd0;
      2'd1:    sub_off = 32'd1;
      2'd2:    sub_off = 32'(bsf_pkg::SCREEN_WIDTH);
      default: sub_off = 32'(bsf_pkg::SCREEN_WIDTH) + 32'd1;
    endcase
  end

  assign res_kind = (step_r < npix) ? bsf_pkg::KIND_PIXEL : bsf_pkg::KIND_STATUS;
  assign res_addr = cur_r.addr + sub_off;

  always_comb begin
    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    step_nxt      = step_r;
    if (q_pop) begin
      cur_nxt       = q_job;
      cur_valid_nxt = 1'b1;
      step_nxt      = '0;
    end else if (job_done) begin
      cur_valid_nxt = 1'b0;
    end else if (adv) begin
      step_nxt = step_r + 3'd1;
    end
    out_valid_nxt = out_valid_r;
    if (!out_valid_r || !out_stall) begin
      out_valid_nxt = adv;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (adv) begin
      kind_r <= res_kind;
      last_r <= is_last;
      if (res_kind == bsf_pkg::KIND_PIXEL) begin
        addr_r   <= res_addr;
        pixel_r  <= cur_r.pixel;
        status_r <= bsf_pkg::ST_OK;
      end else begin
        addr_r   <= '0;
        pixel_r  <= '0;
        status_r <= cur_r.st;
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign out_kind    = kind_r;
  assign out_address = addr_r;
  assign out_pixel   = pixel_r;
  assign out_status  = status_r;
  assign out_last    = last_r;

  // a status result always closes its job
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && kind_r == bsf_pkg::KIND_STATUS |-> last_r)
    else $error("status result without last");

  // step never runs past the job's result count
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> step_r < nres)
    else $error("sequencer step out of range");

  // a job never leaves the sequencer while its output is blocked
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r && out_valid_r && out_stall |=> cur_valid_r && $stable(step_r))
    else $error("sequencer advanced under stall");

endmodule

### design/bmp_stream_to_framebuffer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_stream_to_framebuffer_core: 8-bit greyscale BMP loader
// Parses a BMP byte stream and emits framebuffer writes and a final status.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one item per accepted cycle: operation (start, data byte, end)
//           and the data byte. Accepted when in_valid is high and in_stall
//           is low.
//   out_* : results (pixel write or final status), out_last marks the last
//           result caused by an input item. Taken when out_valid is high and
//           out_stall is low.
//   cfg_* : pixel_base write port, always ready; write only while idle.
// An accepted item's job passes the job queue, the sequencer's current-job
//   register and the registered output stage. Throughput: one item per
//   cycle for full size images while out_stall is low; half size images
//   produce four writes per pixel byte, all through the single result port.
// A 4-entry job queue sits between parser and write sequencer, so input
//   is still accepted while results are stalled, until the queue fills.
// Reset clears the parser to the header phase, empties the queue and
//   sets pixel_base to zero.
// ----------------------------------------------------------------------------
module bmp_stream_to_framebuffer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [31:0] out_address,
  output logic [7:0]  out_pixel,
  output logic [2:0]  out_status,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_pixel_base
);

  logic [31:0]   pixel_base_r;
  logic          acc;
  logic          push, pop, q_full, q_empty;
  bsf_pkg::job_t push_job, pop_job;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign acc       = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_base_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      pixel_base_r <= cfg_pixel_base;
    end
  end

  bsf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .operation  (in_operation),
    .data_byte  (in_data_byte),
    .pixel_base (pixel_base_r),
    .push       (push),
    .job        (push_job)
  );

  bsf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  bsf_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_job       (pop_job),
    .q_empty     (q_empty),
    .q_pop       (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_kind    (out_kind),
    .out_address (out_address),
    .out_pixel   (out_pixel),
    .out_status  (out_status),
    .out_last    (out_last)
  );

endmodule

### tb/sv/bmp_write_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_write_checker: predicts and checks framebuffer writes and load status
// Watches the item, result and pixel_base channels of the BMP loader. Keeps
// its own copy of the parser state, works out the writes and status each
// accepted item should cause, and compares every result field by field.
// ----------------------------------------------------------------------------
module bmp_write_checker
  import bsf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_data_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_kind,
  input  logic [31:0] out_address,
  input  logic [7:0]  out_pixel,
  input  logic [2:0]  out_status,
  input  logic        out_last,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [31:0] cfg_pixel_base,
  output int          fail_count,
  output int          pending,
  output int          checked
);

  typedef struct packed {
    logic        kind;
    logic [31:0] addr;
    logic [7:0]  pixel;
    logic [2:0]  status;
    logic        last;
  } fb_result_t;

  fb_result_t due_results[$];

  // parser copy
  phase_t      ph;
  logic [10:0] hdr_pos;
  logic [15:0] sig;
  logic [31:0] img_w;
  logic [31:0] img_h;
  logic        dbl;
  logic [7:0]  row;
  logic [8:0]  col;
  logic [31:0] base;

  initial begin
    fail_count = 0;
    pending    = 0;
    checked    = 0;
  end

  function automatic fb_result_t pix_result(input logic [31:0] a, input logic [7:0] b);
    return '{kind: KIND_PIXEL, addr: a, pixel: b, status: ST_OK, last: 1'b0};
  endfunction

  function automatic fb_result_t stat_result(input status_t st);
    return '{kind: KIND_STATUS, addr: 32'd0, pixel: 8'd0, status: st, last: 1'b0};
  endfunction

  task automatic clear_parse();
    ph      = PH_HEADER;
    hdr_pos = '0;
    sig     = '0;
    img_w   = '0;
    img_h   = '0;
    dbl     = 1'b0;
    row     = '0;
    col     = '0;
  endtask

  task automatic header_byte(input logic [7:0] b, ref fb_result_t batch[$]);
    int unsigned pos;
    pos = hdr_pos;
    if (pos < SIG_END)
      sig = sig | (16'(b) << (8 * pos));
    else if (pos >= WIDTH_POS && pos < WIDTH_POS + FIELD_LEN)
      img_w = img_w | (32'(b) << (8 * (pos - WIDTH_POS)));
    else if (pos >= HEIGHT_POS && pos < HEIGHT_POS + FIELD_LEN)
      img_h = img_h | (32'(b) << (8 * (pos - HEIGHT_POS)));
    hdr_pos = 11'(pos + 1);
    if (pos == HEADER_BYTES - 1) begin
      // signature is checked before size
      if (sig != SIG_BM) begin
        batch.push_back(stat_result(ST_BAD_SIG));
        ph = PH_DONE;
      end else if ((img_w == HALF_WIDTH && img_h == HALF_HEIGHT) ||
                   (img_w == SCREEN_WIDTH && img_h == SCREEN_HEIGHT)) begin
        dbl = (img_w == HALF_WIDTH);
        ph  = PH_PIXELS;
        row = 8'(img_h - 32'd1);
        col = '0;
      end else begin
        batch.push_back(stat_result(ST_BAD_SIZE));
        ph = PH_DONE;
      end
    end
  endtask

  task automatic pixel_byte(input logic [7:0] b, ref fb_result_t batch[$]);
    logic [31:0] top_addr;
    if (dbl) begin
      top_addr = base + 32'(row) * 32'd2 * SCREEN_WIDTH + 32'(col) * 32'd2;
      batch.push_back(pix_result(top_addr, b));
      batch.push_back(pix_result(top_addr + 32'd1, b));
      batch.push_back(pix_result(top_addr + SCREEN_WIDTH, b));
      batch.push_back(pix_result(top_addr + SCREEN_WIDTH + 32'd1, b));
    end else begin
      batch.push_back(pix_result(base + 32'(row) * SCREEN_WIDTH + 32'(col), b));
    end
    col = col + 9'd1;
    if (32'(col) >= img_w) begin
      col = '0;
      // rows arrive bottom first, so row 0 closes the image
      if (row == 8'd0) begin
        batch.push_back(stat_result(ST_OK));
        ph = PH_DONE;
      end else begin
        row = row - 8'd1;
      end
    end
  endtask

  task automatic frame_step(input logic [1:0] op, input logic [7:0] b);
    fb_result_t batch[$];
    case (op)
      OP_START: clear_parse();
      OP_DATA: begin
        if (ph == PH_HEADER)
          header_byte(b, batch);
        else if (ph == PH_PIXELS)
          pixel_byte(b, batch);
      end
      OP_END: begin
        if (ph == PH_HEADER) begin
          batch.push_back(stat_result(ST_SHORT_HDR));
          ph = PH_DONE;
        end else if (ph == PH_PIXELS) begin
          batch.push_back(stat_result(ST_SHORT_PIX));
          ph = PH_DONE;
        end
      end
      default: ;
    endcase
    if (batch.size() > 0)
      batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i])
      due_results.push_back(batch[i]);
  endtask

  task automatic check_field(input string field, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    fb_result_t want;
    if (!rst_n) begin
      base = '0;
      clear_parse();
      due_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        checked++;
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, got kind %0d addr %0h",
                   $time, out_kind, out_address);
          $display("%0t:   pixel %0h status %0d", $time, out_pixel, out_status);
          fail_count++;
        end else begin
          want = due_results.pop_front();
          check_field("kind", 32'(want.kind), 32'(out_kind));
          check_field("address", want.addr, out_address);
          check_field("pixel", 32'(want.pixel), 32'(out_pixel));
          check_field("status", 32'(want.status), 32'(out_status));
          check_field("last", 32'(want.last), 32'(out_last));
        end
      end
      if (cfg_valid && cfg_ready)
        base = cfg_pixel_base;
      if (in_valid && !in_stall)
        frame_step(in_operation, in_data_byte);
    end
    pending = due_results.size();
  end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: BMP stream to framebuffer core testbench
// Feeds whole and truncated 8-bit BMP files (doubled and 1:1 sizes, bad
// signatures and sizes, short headers and pixel data) with random gaps and
// result stalls, moves pixel_base between files, and reports the verdict.
// ----------------------------------------------------------------------------
module tb;
  import bsf_pkg::*;

  typedef enum int {
    FILE_HALF,
    FILE_FULL,
    FILE_BAD_SIG,
    FILE_BAD_SIZE,
    FILE_SHORT_HDR
  } file_kind_t;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int N_FILES = 22;
  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 8;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_operation;
  logic [7:0]  in_data_byte;
  logic        out_valid;
  logic        out_stall;
  logic        out_kind;
  logic [31:0] out_address;
  logic [7:0]  out_pixel;
  logic [2:0]  out_status;
  logic        out_last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_pixel_base;

  int fail_count;
  int pending;
  int checked;
  int cyc;
  int quiet;
  int items_fed;
  int files_fed;
  int base_writes;
  logic calm;

  bmp_stream_to_framebuffer_core u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_data_byte   (in_data_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_address    (out_address),
    .out_pixel      (out_pixel),
    .out_status     (out_status),
    .out_last       (out_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_pixel_base (cfg_pixel_base)
  );

  bmp_write_checker u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_data_byte   (in_data_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_address    (out_address),
    .out_pixel      (out_pixel),
    .out_status     (out_status),
    .out_last       (out_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_pixel_base (cfg_pixel_base),
    .fail_count     (fail_count),
    .pending        (pending),
    .checked        (checked)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // periodic stretch with no gaps or stalls on either side
  assign calm = (cyc % 30000) < 5000;

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (rst_n && !(in_valid && !in_stall) && !(out_valid && !out_stall) &&
        !(cfg_valid && cfg_ready))
      quiet <= quiet + 1;
    else
      quiet <= 0;
    if (quiet >= STALL_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles, %0d results outstanding",
               STALL_LIMIT, pending);
      $display("FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 15);
  end

  task automatic feed_item(input logic [1:0] op, input logic [7:0] b);
    while (!calm && $urandom_range(0, 99) < 15) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_data_byte <= b;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    items_fed++;
  endtask

  // lower valid, let all results drain, then give the pipeline time to settle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_pixel_base(input logic [31:0] v);
    cfg_valid      <= 1'b1;
    cfg_pixel_base <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    base_writes++;
  endtask

  task automatic feed_file(input file_kind_t fk, input bit whole);
    logic [15:0] sig;
    logic [31:0] w;
    logic [31:0] h;
    logic [7:0]  b;
    int          cut;
    int          n_pix;
    sig = SIG_BM;
    w   = HALF_WIDTH;
    h   = HALF_HEIGHT;
    cut = HEADER_BYTES;
    case (fk)
      FILE_FULL: begin
        w = SCREEN_WIDTH;
        h = SCREEN_HEIGHT;
      end
      FILE_BAD_SIG: begin
        case ($urandom_range(0, 3))
          0: sig = {SIG_BM[7:0], SIG_BM[15:8]};
          1: sig = {8'h4E, SIG_BM[7:0]};
          2: sig = 16'h0000;
          default: do sig = 16'($urandom); while (sig == SIG_BM);
        endcase
        if ($urandom_range(0, 1)) begin
          w = SCREEN_WIDTH;
          h = SCREEN_HEIGHT;
        end
      end
      FILE_BAD_SIZE: begin
        case ($urandom_range(0, 4))
          0: begin w = SCREEN_WIDTH; h = HALF_HEIGHT; end
          1: begin w = HALF_WIDTH; h = SCREEN_HEIGHT; end
          2: begin w = SCREEN_WIDTH | 32'h0100_0000; h = SCREEN_HEIGHT; end
          3: begin w = HALF_WIDTH; h = HALF_HEIGHT | 32'h8000_0000; end
          default: begin w = $urandom; h = $urandom; end
        endcase
      end
      FILE_SHORT_HDR: begin
        if ($urandom_range(0, 1)) begin
          w = SCREEN_WIDTH;
          h = SCREEN_HEIGHT;
        end
        cut = $urandom_range(0, HEADER_BYTES - 1);
      end
      default: ;
    endcase

    feed_item(OP_START, 8'($urandom));
    files_fed++;
    for (int pos = 0; pos < cut; pos++) begin
      b = 8'($urandom);
      if (pos < SIG_END)
        b = sig[8*pos +: 8];
      else if (pos >= WIDTH_POS && pos < WIDTH_POS + FIELD_LEN)
        b = w[8*(pos - WIDTH_POS) +: 8];
      else if (pos >= HEIGHT_POS && pos < HEIGHT_POS + FIELD_LEN)
        b = h[8*(pos - HEIGHT_POS) +: 8];
      if ($urandom_range(0, 99) == 0)
        feed_item(OP_UNUSED, 8'($urandom));
      feed_item(OP_DATA, b);
    end

    if (fk == FILE_SHORT_HDR) begin
      feed_item(OP_END, 8'($urandom));
    end else if (fk == FILE_HALF || fk == FILE_FULL) begin
      n_pix = whole ? int'(w * h) : $urandom_range(0, 2 * w + 3);
      for (int i = 0; i < n_pix; i++) begin
        if ($urandom_range(0, 199) == 0)
          feed_item(OP_UNUSED, 8'($urandom));
        feed_item(OP_DATA, 8'($urandom));
      end
      if (!whole && $urandom_range(0, 9) < 7)
        feed_item(OP_END, 8'($urandom));
    end

    // stray items after the file; ignored once the load is done
    repeat ($urandom_range(0, 2))
      feed_item($urandom_range(0, 1) ? OP_DATA : OP_END, 8'($urandom));
  endtask

  initial begin
    file_kind_t fk;
    int r;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_operation   = OP_START;
    in_data_byte   = 8'd0;
    out_stall      = 1'b0;
    cfg_valid      = 1'b0;
    cfg_pixel_base = 32'd0;
    cyc            = 0;
    quiet          = 0;
    items_fed      = 0;
    files_fed      = 0;
    base_writes    = 0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: unused op, end in header and in done, byte extremes
    feed_item(OP_UNUSED, 8'hFF);
    feed_item(OP_END, 8'h00);
    feed_item(OP_END, 8'hFF);
    feed_item(OP_DATA, 8'h00);
    feed_item(OP_START, 8'hFF);
    feed_item(OP_DATA, 8'h00);
    feed_item(OP_DATA, 8'hFF);
    feed_item(OP_DATA, 8'h55);
    feed_item(OP_DATA, 8'hAA);
    feed_item(OP_UNUSED, 8'h00);
    feed_item(OP_END, 8'h5A);
    feed_item(OP_START, 8'h00);
    feed_item(OP_END, 8'hA5);

    for (int f = 0; f < N_FILES; f++) begin
      if (f % 3 == 0) begin
        drain_results();
        if (f == 0)
          set_pixel_base(32'hFFFF_FFFF);
        else if (f == 3)
          set_pixel_base(32'hFFFF_F000);
        else
          case ($urandom_range(0, 3))
            0: set_pixel_base(32'h0000_0000);
            1: set_pixel_base(32'hFFFF_FFFF);
            default: set_pixel_base($urandom);
          endcase
      end
      case (f)
        0: feed_file(FILE_BAD_SIG, 1'b0);
        1: feed_file(FILE_BAD_SIZE, 1'b0);
        2: feed_file(FILE_SHORT_HDR, 1'b0);
        3: feed_file(FILE_HALF, 1'b1);
        4: feed_file(FILE_FULL, 1'b1);
        default: begin
          r = $urandom_range(0, 99);
          if (r < 35)      fk = FILE_HALF;
          else if (r < 65) fk = FILE_FULL;
          else if (r < 77) fk = FILE_BAD_SIG;
          else if (r < 89) fk = FILE_BAD_SIZE;
          else             fk = FILE_SHORT_HDR;
          feed_file(fk, 1'b0);
        end
      endcase
    end

    drain_results();
    repeat (20) @(negedge clk);

    $display("Fed %0d items in %0d files: doubled and 1:1 images, bad signature and size,",
             items_fed, files_fed);
    $display("truncated headers and pixel data; %0d results compared over %0d base settings.",
             checked, base_writes);
    if (fail_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

### sim.f
design/bsf_pkg.sv
design/bsf_front.sv
design/bsf_queue.sv
design/bsf_back.sv
design/bmp_stream_to_framebuffer_core.sv
tb/sv/bmp_write_checker.sv
tb/sv/tb.sv
